// ===== rtl/core/frt_pkg.sv =====
// shared types and constants of the fragment reassembly tracker
package frt_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] KIND_FRAG  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BYTE_ORDER = 2'd0;
    localparam logic [1:0] REG_REQ_SIZE   = 2'd1;
    localparam logic [1:0] REG_FRAG_COUNT = 2'd2;

    localparam int          CNT_W    = 11;
    localparam int          TICK_W   = 16;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;
    localparam int          BIT_W    = 5;

    // beat widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 32;

    // fragment check result handed to the control
    typedef struct packed {
        logic hdr_ok;
        logic id_ok;
    } t_check;

    // control states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROC  = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

endpackage

// ===== rtl/core/frt_bitmap_ram.sv =====
// single port write, single port read bitmap memory with registered read data
module frt_bitmap_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/frt_frag_check.sv =====
// header and byte range check plus bitmap address decode of a fragment beat
module frt_frag_check #(
    parameter int MAX_FRAGMENTS = 1024,
    parameter int AW            = 5
) (
    input  logic                          i_byte_order,
    input  logic [31:0]                   i_request_size,
    input  logic [31:0]                   i_fragment_size,
    input  logic [31:0]                   i_fragment_offset,
    input  logic [31:0]                   i_fragment_total,
    input  logic [31:0]                   i_fragment_index,
    input  logic                          i_exp_byte_order,
    input  logic [31:0]                   i_exp_req_size,
    input  logic [frt_pkg::CNT_W-1:0]     i_exp_frag_count,
    output frt_pkg::t_check               o_check,
    output logic [AW-1:0]                 o_word,
    output logic [frt_pkg::BIT_W-1:0]     o_bit
);

    localparam logic [31:0] MAX_ID = 32'(MAX_FRAGMENTS);

    logic [32:0] end_byte;
    logic [31:0] exp_total;

    // end of the byte range without wrap
    assign end_byte  = {1'b0, i_fragment_offset} + {1'b0, i_fragment_size};
    assign exp_total = {{(32 - frt_pkg::CNT_W){1'b0}}, i_exp_frag_count};

    assign o_check.hdr_ok = (i_byte_order == i_exp_byte_order) &&
                            (i_request_size == i_exp_req_size) &&
                            (i_fragment_total == exp_total) &&
                            (i_fragment_offset < i_request_size) &&
                            (end_byte <= {1'b0, i_request_size});

    // id inside both the request and the bitmap
    assign o_check.id_ok = (i_fragment_index < exp_total) && (i_fragment_index < MAX_ID);

    assign o_word = i_fragment_index[frt_pkg::BIT_W +: AW];
    assign o_bit  = i_fragment_index[frt_pkg::BIT_W-1:0];

endmodule

// ===== rtl/core/fragment_reassembly_tracker_top.sv =====
// fragment reassembly tracker top: bitmap memory with read-modify-write control
// a result is registered once the beat's bitmap word is read and the output register is free,
// for every beat kind; beats are taken one at a time (bitmap read, then write back); a stalled result
// holds the next beat in processing while it waits in the output register
// a clear beat is followed by a sweep that zeroes every bitmap word with the input held off
// reset (synchronous, active low) zeroes the configuration registers and counts, then sweeps the bitmap
module fragment_reassembly_tracker_top #(
    parameter int MAX_FRAGMENTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte_order[0], request_size[32:1], fragment_size[64:33], fragment_offset[96:65],
    // fragment_total[128:97], fragment_index[160:129], zero fill[167:161]
    input  logic [167:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // header_ok[0], duplicate[1], newly_marked[2], request_complete[3],
    // timeout_ticks[19:4], received_total[30:20], zero fill[31]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORDS = (MAX_FRAGMENTS + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    // configuration registers
    logic                        r_exp_byte_order;
    logic [31:0]                 r_exp_req_size;
    logic [frt_pkg::CNT_W-1:0]   r_exp_frag_count;

    // control and tracking state
    frt_pkg::t_state             r_state, n_state;
    logic [AW-1:0]               r_clr_addr;
    logic [frt_pkg::CNT_W-1:0]   r_rcv_cnt, n_rcv_cnt;
    logic [frt_pkg::TICK_W-1:0]  r_tick_cnt, n_tick_cnt;

    // item held between accept and result
    logic [1:0]                  r_kind;
    frt_pkg::t_check             r_chk;
    logic [AW-1:0]               r_word;
    logic [frt_pkg::BIT_W-1:0]   r_bit;

    // output register
    logic                        r_out_valid;
    logic [31:0]                 r_out_data;

    frt_pkg::t_check             chk;
    logic [AW-1:0]               word;
    logic [frt_pkg::BIT_W-1:0]   bit_idx;
    logic [31:0]                 rd_data;
    logic [31:0]                 bit_mask;
    logic                        s_accept;
    logic                        cfg_write;
    logic                        out_free;
    logic                        proc_fire;
    logic                        is_frag;
    logic                        dup;
    logic                        mark;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [31:0]                 mem_wdata;
    logic [31:0]                 res_data;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_byte_order <= 1'b0;
            r_exp_req_size   <= '0;
            r_exp_frag_count <= '0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                frt_pkg::REG_BYTE_ORDER: r_exp_byte_order <= pwdata[0];
                frt_pkg::REG_REQ_SIZE:   r_exp_req_size   <= pwdata;
                frt_pkg::REG_FRAG_COUNT: r_exp_frag_count <= pwdata[frt_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        case (paddr[3:2])
            frt_pkg::REG_BYTE_ORDER: prdata = {31'b0, r_exp_byte_order};
            frt_pkg::REG_REQ_SIZE:   prdata = r_exp_req_size;
            frt_pkg::REG_FRAG_COUNT: prdata = {{(32 - frt_pkg::CNT_W){1'b0}}, r_exp_frag_count};
            default:                 prdata = '0;
        endcase
    end

    // fragment check on the incoming beat
    frt_frag_check #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .AW            (AW)
    ) u_check (
        .i_byte_order      (s_axis_tdata[0]),
        .i_request_size    (s_axis_tdata[32:1]),
        .i_fragment_size   (s_axis_tdata[64:33]),
        .i_fragment_offset (s_axis_tdata[96:65]),
        .i_fragment_total  (s_axis_tdata[128:97]),
        .i_fragment_index  (s_axis_tdata[160:129]),
        .i_exp_byte_order  (r_exp_byte_order),
        .i_exp_req_size    (r_exp_req_size),
        .i_exp_frag_count  (r_exp_frag_count),
        .o_check           (chk),
        .o_word            (word),
        .o_bit             (bit_idx)
    );

    // bitmap, read at accept and written back when the result is formed
    frt_bitmap_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (s_accept),
        .i_raddr (word),
        .o_rdata (rd_data)
    );

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind <= s_axis_tuser;
            r_chk  <= chk;
            r_word <= word;
            r_bit  <= bit_idx;
        end
    end

    // result logic on the read data
    assign out_free  = !r_out_valid || m_axis_tready;
    assign proc_fire = (r_state == frt_pkg::S_PROC) && out_free;
    assign is_frag   = (r_kind == frt_pkg::KIND_FRAG);
    assign bit_mask  = 32'b1 << r_bit;
    assign dup       = r_chk.id_ok ? ((rd_data & bit_mask) != '0) : 1'b1;
    assign mark      = is_frag && r_chk.hdr_ok && !dup;

    // memory write: mark during processing, zero during the sweep
    assign mem_we    = (proc_fire && mark) || (r_state == frt_pkg::S_CLEAR);
    assign mem_waddr = (r_state == frt_pkg::S_CLEAR) ? r_clr_addr : r_word;
    assign mem_wdata = (r_state == frt_pkg::S_CLEAR) ? 32'b0 : (rd_data | bit_mask);

    // next counts
    always_comb begin
        n_rcv_cnt  = r_rcv_cnt;
        n_tick_cnt = r_tick_cnt;
        if (proc_fire) begin
            case (r_kind)
                frt_pkg::KIND_FRAG: begin
                    if (mark) begin
                        n_rcv_cnt = r_rcv_cnt + 1'b1;
                    end
                end
                frt_pkg::KIND_TICK: begin
                    if (r_tick_cnt != frt_pkg::TICK_MAX) begin
                        n_tick_cnt = r_tick_cnt + 1'b1;
                    end
                end
                frt_pkg::KIND_CLEAR: begin
                    n_rcv_cnt  = '0;
                    n_tick_cnt = '0;
                end
                default: ;
            endcase
        end
    end

    assign res_data = {1'b0, n_rcv_cnt, n_tick_cnt, (n_rcv_cnt == r_exp_frag_count),
                       mark, is_frag && dup, is_frag && r_chk.hdr_ok};

    // control state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            frt_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_state = frt_pkg::S_PROC;
                end
            end
            frt_pkg::S_PROC: begin
                if (proc_fire) begin
                    n_state = (r_kind == frt_pkg::KIND_CLEAR) ? frt_pkg::S_CLEAR : frt_pkg::S_IDLE;
                end
            end
            frt_pkg::S_CLEAR: begin
                if (r_clr_addr == LAST_WORD) begin
                    n_state = frt_pkg::S_IDLE;
                end
            end
            default: n_state = frt_pkg::S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == frt_pkg::S_IDLE);

    // state, counts and sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= frt_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_rcv_cnt  <= '0;
            r_tick_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_rcv_cnt  <= n_rcv_cnt;
            r_tick_cnt <= n_tick_cnt;
            if (r_state == frt_pkg::S_CLEAR) begin
                r_clr_addr <= (r_clr_addr == LAST_WORD) ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_data <= res_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // no beat is taken while the bitmap is swept
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frt_pkg::S_CLEAR) |-> !s_axis_tready)
        else $error("beat accepted during bitmap sweep");

    // a marking write is followed by a result that reports the mark
    a_mark_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && mark) |=> (m_axis_tvalid && m_axis_tdata[2] && m_axis_tdata[0]))
        else $error("marked fragment not reported");

    // the received count only steps by one or returns to zero
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_rcv_cnt == $past(r_rcv_cnt)) || (r_rcv_cnt == $past(r_rcv_cnt) + 1'b1) ||
                 (r_rcv_cnt == '0))
        else $error("received count jumped");

    // a result is only formed when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
        else $error("pending result overwritten");

endmodule
